// File: sv/ptg_pkg.sv
package ptg_pkg;

    localparam int DELAY_W   = 24;
    localparam int HIGH_W    = 24;
    localparam int COUNT_W   = 16;
    localparam int PEND_W    = 8;
    localparam int TASK_W    = 8;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam int PENDING_LIMIT = 256;
    localparam logic [PEND_W:0] EFF_LIMIT =
        (PENDING_LIMIT > 255) ? (PEND_W+1)'(255) : (PEND_W+1)'(PENDING_LIMIT);

    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TRIGGER = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEAD,
        PH_HIGH,
        PH_LOW
    } t_phase;

    typedef enum logic [1:0] {
        KIND_SINGLE,
        KIND_TRAIN,
        KIND_INF
    } t_kind;

    typedef struct packed {
        logic [DELAY_W-1:0] delay_ticks;
        logic [HIGH_W-1:0]  high_ticks;
        logic [COUNT_W-1:0] pulse_count;
    } t_cfg;

    typedef struct packed {
        t_phase              phase;
        logic [DELAY_W-1:0]  ticks_left;
        logic [COUNT_W-1:0]  pulses_left;
        logic [PEND_W-1:0]   pending;
        logic                infinite_run;
        logic                level;
        t_kind               kind;
    } t_state;

    typedef struct packed {
        logic              level;
        logic              task_done;
        logic              accepted;
        logic [PEND_W-1:0] pending;
        logic              busy;
    } t_result;

    function automatic t_state enter_high(t_state s, t_cfg c);
        t_state r;
        r = s;
        r.phase      = PH_HIGH;
        r.ticks_left = (c.high_ticks == '0) ? DELAY_W'(1) : c.high_ticks;
        r.level      = 1'b1;
        return r;
    endfunction

    function automatic t_state go_idle(t_state s);
        t_state r;
        r = s;
        r.phase       = PH_IDLE;
        r.ticks_left  = '0;
        r.pulses_left = '0;
        r.level       = 1'b0;
        return r;
    endfunction

    function automatic t_state start_next(t_state s, t_cfg c);
        t_state r;
        r = s;
        if (s.pending != '0) begin
            if (c.pulse_count <= COUNT_W'(1)) begin
                r.kind        = KIND_SINGLE;
                r.pulses_left = '0;
                if (c.delay_ticks != '0) begin
                    r.phase      = PH_LEAD;
                    r.ticks_left = c.delay_ticks;
                    r.level      = 1'b0;
                end else begin
                    r = enter_high(r, c);
                end
            end else begin
                r.kind        = KIND_TRAIN;
                r.pulses_left = c.pulse_count;
                r = enter_high(r, c);
            end
        end else if (s.infinite_run) begin
            r.kind        = KIND_INF;
            r.pulses_left = '0;
            r = enter_high(r, c);
        end else begin
            r = go_idle(r);
        end
        return r;
    endfunction

endpackage

// File: sv/ptg_step.sv
module ptg_step (
    input  ptg_pkg::t_state                  i_state,
    input  ptg_pkg::t_cfg                    i_cfg,
    input  logic [ptg_pkg::REQ_W-1:0]        i_req,
    input  logic [ptg_pkg::TASK_W-1:0]       i_cnt,
    output ptg_pkg::t_state                  o_state,
    output ptg_pkg::t_result                 o_result
);
    import ptg_pkg::*;

    t_state                s;
    logic                  done;
    logic                  acc;
    logic [DELAY_W-1:0]    left_dec;
    logic [PEND_W:0]       pend_sum;

    assign left_dec = (i_state.ticks_left != '0) ? i_state.ticks_left - DELAY_W'(1) : '0;
    assign pend_sum = {1'b0, i_state.pending} + {1'b0, i_cnt};

    always_comb begin
        s    = i_state;
        done = 1'b0;
        acc  = 1'b0;
        case (i_req)
            REQ_TICK: begin
                if (i_state.phase != PH_IDLE) begin
                    s.ticks_left = left_dec;
                    if (left_dec == '0) begin
                        if (i_state.phase == PH_LEAD) begin
                            s = enter_high(s, i_cfg);
                        end else if (i_state.phase == PH_HIGH && i_state.kind != KIND_SINGLE
                                     && i_cfg.delay_ticks != '0) begin
                            s.phase      = PH_LOW;
                            s.ticks_left = i_cfg.delay_ticks;
                            s.level      = 1'b0;
                        end else if (i_state.kind == KIND_TRAIN
                                     && i_state.pulses_left > COUNT_W'(1)) begin
                            s.pulses_left = i_state.pulses_left - COUNT_W'(1);
                            s = enter_high(s, i_cfg);
                        end else begin
                            done = 1'b1;
                            if (i_state.kind != KIND_INF && i_state.pending != '0) begin
                                s.pending = i_state.pending - PEND_W'(1);
                            end
                            s = go_idle(s);
                            s = start_next(s, i_cfg);
                        end
                    end
                end
            end
            REQ_TRIGGER: begin
                if (i_cfg.pulse_count == '0) begin
                    s.infinite_run = 1'b1;
                    acc = 1'b1;
                end else if (pend_sum <= EFF_LIMIT) begin
                    s.pending = pend_sum[PEND_W-1:0];
                    acc = 1'b1;
                end
                if (acc && i_state.phase == PH_IDLE) begin
                    s = start_next(s, i_cfg);
                end
            end
            REQ_STOP: begin
                s.infinite_run = 1'b0;
            end
            default: begin
                s = i_state;
            end
        endcase
    end

    assign o_state            = s;
    assign o_result.level     = s.level;
    assign o_result.task_done = done;
    assign o_result.accepted  = acc;
    assign o_result.pending   = s.pending;
    assign o_result.busy      = (s.phase != PH_IDLE);

endmodule

// File: sv/pulse_train_generator.sv
// Channel   Direction  Payload
// s_axis    in         tuser: req_type; tdata: task_count
// m_axis    out        tdata: level, task_done, accepted, pending, busy_res
// cfg       in         plain write: delay_ticks, high_ticks, pulse_count
//
// One transaction per cycle unless m_axis stalls; via input, then result register.
// The state update for each transaction is one pass of logic from the input
// register into the state and result registers.
// Synchronous active-low reset: state idle, valid flags clear, cfg at defaults.
// A stalled m_axis holds its result; s_axis keeps accepting into the input
// register until that register is also full.
module pulse_train_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] task_count
    input  logic [1:0]                          s_axis_tuser,  // [1:0] req_type
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] level, [1] task_done, [2] accepted, [10:3] pending, [11] busy_res
    output logic [15:0]                         m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [ptg_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ptg_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ptg_pkg::*;

    t_cfg               r_cfg;
    t_state             r_state;
    t_state             n_state;
    t_result            n_result;
    t_result            r_result;
    logic               r_in_valid;
    logic [REQ_W-1:0]   r_in_req;
    logic [TASK_W-1:0]  r_in_cnt;
    logic               r_out_valid;
    logic               advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    ptg_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_req    (r_in_req),
        .i_cnt    (r_in_cnt),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay_ticks <= '0;
            r_cfg.high_ticks  <= HIGH_W'(1);
            r_cfg.pulse_count <= COUNT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DELAY: r_cfg.delay_ticks <= i_cfg_data[DELAY_W-1:0];
                CFG_HIGH:  r_cfg.high_ticks  <= i_cfg_data[HIGH_W-1:0];
                CFG_COUNT: r_cfg.pulse_count <= i_cfg_data[COUNT_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_IDLE;
            r_state.ticks_left   <= '0;
            r_state.pulses_left  <= '0;
            r_state.pending      <= '0;
            r_state.infinite_run <= 1'b0;
            r_state.level        <= 1'b0;
            r_state.kind         <= KIND_SINGLE;
            r_in_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req <= s_axis_tuser;
            r_in_cnt <= s_axis_tdata;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_result.busy, r_result.pending, r_result.accepted,
                            r_result.task_done, r_result.level};

    a_idle_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_IDLE |-> !r_state.level)
        else $error("level high while idle");

    a_pend_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_state.pending} <= EFF_LIMIT)
        else $error("pending count above limit");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_state))
        else $error("input item lost or state moved while stalled");

    a_result_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.level && !r_result.busy))
        else $error("result level high without busy");

endmodule
